[src/xtea_pkg.sv]
// Shared types and constants for the XTEA block cipher unit.
// No dependencies; imported by every module of the unit.
package xtea_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned STAGES = 2 * ROUNDS;   // one half-round per stage
  localparam int unsigned ADDR_W = 4;            // four 32-bit key words at 4*i
  localparam logic [31:0] DELTA  = 32'h9E37_79B9;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_e;

  typedef logic [3:0][31:0] key_t;

  // Request travelling down the round pipeline
  typedef struct packed {
    logic        valid;
    op_e         op;
    logic [31:0] v0;
    logic [31:0] v1;
    logic        last;
  } pipe_t;

endpackage

[src/xtea_cfg.sv]
// APB-style key register file: four 32-bit key words.
// Depends on xtea_pkg.
module xtea_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xtea_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output xtea_pkg::key_t             keys_o
);
  import xtea_pkg::*;

  key_t keys_q;
  logic wr_en;
  reg_e wr_reg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_reg = reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else if (wr_en) begin
      unique case (wr_reg)
        REG_KEY0: keys_q[0] <= pwdata;
        REG_KEY1: keys_q[1] <= pwdata;
        REG_KEY2: keys_q[2] <= pwdata;
        REG_KEY3: keys_q[3] <= pwdata;
      endcase
    end
  end

  assign prdata = keys_q[paddr[ADDR_W-1:2]];
  assign keys_o = keys_q;

endmodule

[src/xtea_stage.sv]
// One registered XTEA half-round, shared by encrypt and decrypt.
// Depends on xtea_pkg; the round sums arrive as constant inputs.
module xtea_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xtea_pkg::key_t      keys_i,
  input  logic [31:0]         enc_sum_i,
  input  logic [31:0]         dec_sum_i,
  input  logic                half_i,
  input  xtea_pkg::pipe_t     pipe_i,
  output xtea_pkg::pipe_t     pipe_o
);
  import xtea_pkg::*;

  pipe_t pipe_d;
  pipe_t pipe_q;

  // Encrypt updates v0 in the first half, decrypt in the second.
  always_comb begin
    logic        upd_v0;
    logic [31:0] sum;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] mix;
    logic [31:0] f;
    logic [31:0] res;
    logic [1:0]  kidx;

    upd_v0 = (pipe_i.op == OP_ENC) ? !half_i : half_i;
    sum    = (pipe_i.op == OP_ENC) ? enc_sum_i : dec_sum_i;
    kidx   = upd_v0 ? sum[1:0] : sum[12:11];
    src    = upd_v0 ? pipe_i.v1 : pipe_i.v0;
    dst    = upd_v0 ? pipe_i.v0 : pipe_i.v1;
    mix    = ((src << 4) ^ (src >> 5)) + src;
    f      = mix ^ (sum + keys_i[kidx]);
    res    = (pipe_i.op == OP_ENC) ? dst + f : dst - f;

    pipe_d = pipe_i;
    if (upd_v0) begin
      pipe_d.v0 = res;
    end else begin
      pipe_d.v1 = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

[src/xtea_block_cipher_unit.sv]
// XTEA block cipher unit: takes one 64-bit block per clock (start with busy
// low; busy never rises) and returns each result through the pipeline, one
// registered half-round per pipeline stage, on the result ports for a single
// cycle marked by result_valid_o. The receiver cannot stall, so results are
// never held. Results come out in request order. The 128-bit key lives in
// four APB registers at byte addresses 0, 4, 8 and 12; change it only while
// no request is in flight. Depends on xtea_pkg, xtea_cfg and xtea_stage.
module xtea_block_cipher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode_i,
  input  logic [31:0]                 first_half_i,
  input  logic [31:0]                 second_half_i,
  input  logic                        last_block_i,
  output logic                        result_valid_o,
  output logic [31:0]                 first_result_o,
  output logic [31:0]                 second_result_o,
  output logic                        last_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xtea_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import xtea_pkg::*;

  key_t  keys;
  pipe_t pipe [STAGES+1];

  assign busy = 1'b0;

  xtea_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keys_o  (keys)
  );

  assign pipe[0].valid = start && !busy;
  assign pipe[0].op    = op_e'(opcode_i);
  assign pipe[0].v0    = first_half_i;
  assign pipe[0].v1    = second_half_i;
  assign pipe[0].last  = last_block_i;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int unsigned R    = s / 2;
    localparam int unsigned H    = s % 2;
    localparam logic [63:0] ENC  = 64'(R + H) * 64'(DELTA);
    localparam logic [63:0] DEC  = 64'(ROUNDS - R - H) * 64'(DELTA);

    xtea_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .keys_i    (keys),
      .enc_sum_i (ENC[31:0]),
      .dec_sum_i (DEC[31:0]),
      .half_i    (1'(H)),
      .pipe_i    (pipe[s]),
      .pipe_o    (pipe[s+1])
    );
  end

  assign result_valid_o  = pipe[STAGES].valid;
  assign first_result_o  = pipe[STAGES].v0;
  assign second_result_o = pipe[STAGES].v1;
  assign last_out_o      = pipe[STAGES].last;

endmodule

[src/xtea_chk.sv]
// Port-level checker for the XTEA block cipher unit, bound to the top level.
// Depends on xtea_pkg for the pipeline depth.
module xtea_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        last_block_i,
  input logic                        result_valid_o,
  input logic                        last_out_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [xtea_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import xtea_pkg::*;

  logic [STAGES-1:0] acc_q;
  logic [STAGES-1:0] last_q;

  // Shadow of accepted requests, one bit per cycle of latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= {acc_q[STAGES-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= {last_q[STAGES-2:0], last_block_i};
  end

  // Strobe is clear from the first clock edge seen in reset onwards
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !result_valid_o)
    else $error("result strobe during reset");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == acc_q[STAGES-1])
    else $error("result strobe does not follow request at fixed latency");

  a_last_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> last_out_o == last_q[STAGES-1])
    else $error("last flag does not match its request");

  a_key_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready) ##1 (psel && !pwrite && paddr == $past(paddr))
      |-> prdata == $past(pwdata))
    else $error("key register read does not return written value");

endmodule

bind xtea_block_cipher_unit xtea_chk u_chk (.*);

[bench/xtea_block_cipher_unit_tb.sv]
// Self-checking bench for the XTEA block cipher unit: APB key loads with
// read-back, directed and random blocks, results checked against a local model.
// Depends on xtea_pkg and xtea_block_cipher_unit.
`timescale 1ns / 1ps

module xtea_block_cipher_unit_tb;
  import xtea_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PIPE_DEPTH  = STAGES;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic        last;
  } block_t;

  // Key copy, XTEA model and queue of blocks still due from the pipeline
  class xtea_scoreboard;
    logic [31:0] key_words [4];
    block_t      due_blocks [$];
    int unsigned error_count;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      error_count = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
    endtask

    function logic [31:0] mix(logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function block_t cipher(op_e op, block_t blk);
      logic [31:0] v0, v1, sum;
      v0 = blk.w0;
      v1 = blk.w1;
      if (op == OP_ENC) begin
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) begin
          v0 += mix(v1) ^ (sum + key_words[sum[1:0]]);
          sum += DELTA;
          v1 += mix(v0) ^ (sum + key_words[sum[12:11]]);
        end
      end else begin
        sum = 32'(DELTA * ROUNDS);
        for (int r = 0; r < ROUNDS; r++) begin
          v1 -= mix(v0) ^ (sum + key_words[sum[12:11]]);
          sum -= DELTA;
          v0 -= mix(v1) ^ (sum + key_words[sum[1:0]]);
        end
      end
      return '{w0: v0, w1: v1, last: blk.last};
    endfunction

    function void note_request(op_e op, logic [31:0] a, logic [31:0] b, logic last);
      due_blocks.push_back(cipher(op, '{w0: a, w1: b, last: last}));
    endfunction

    task check_result(logic [31:0] a, logic [31:0] b, logic last);
      block_t want;
      if (due_blocks.size() == 0) begin
        report($sformatf("result %h_%h with nothing outstanding", a, b));
        return;
      end
      want = due_blocks.pop_front();
      if (a !== want.w0)
        report($sformatf("first_result %h, want %h", a, want.w0));
      if (b !== want.w1)
        report($sformatf("second_result %h, want %h", b, want.w1));
      if (last !== want.last)
        report($sformatf("last_out %b, want %b", last, want.last));
    endtask

    function int unsigned outstanding();
      return due_blocks.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                opcode_i = 1'b0;
  logic [31:0]         first_half_i = '0;
  logic [31:0]         second_half_i = '0;
  logic                last_block_i = 1'b0;
  logic                result_valid_o;
  logic [31:0]         first_result_o;
  logic [31:0]         second_result_o;
  logic                last_out_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  xtea_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  bit             no_gaps = 1'b0;   // set for the final stretch of the run
  bit             calm_stretch = 1'b0;

  xtea_block_cipher_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .first_half_i   (first_half_i),
    .second_half_i  (second_half_i),
    .last_block_i   (last_block_i),
    .result_valid_o (result_valid_o),
    .first_result_o (first_result_o),
    .second_result_o(second_result_o),
    .last_out_o     (last_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Sample at the edge: values seen here are the ones of the cycle just ended
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        sb.note_request(op_e'(opcode_i), first_half_i, second_half_i, last_block_i);
      if (result_valid_o)
        sb.check_result(first_result_o, second_result_o, last_out_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  task automatic idle_cycles(int unsigned n);
    start         <= 1'b0;
    opcode_i      <= 1'($urandom_range(0, 1));
    first_half_i  <= $urandom();
    second_half_i <= $urandom();
    last_block_i  <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_block(op_e op, logic [31:0] a, logic [31:0] b, logic last);
    start         <= 1'b1;
    opcode_i      <= op;
    first_half_i  <= a;
    second_half_i <= b;
    last_block_i  <= last;
    do @(posedge clk_i); while (busy);
    if (!no_gaps && !calm_stretch && $urandom_range(0, 3) == 0)
      idle_cycles($urandom_range(1, 4));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // APB write, then read back and compare; only called with the pipeline empty
  task automatic program_key(int idx, logic [31:0] value);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_e'(idx), 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.key_words[idx] = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== value)
      sb.report($sformatf("key word %0d reads %h, want %h", idx, got, value));
  endtask

  task automatic load_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                          logic [31:0] k3);
    drain();
    program_key(REG_KEY0, k0);
    program_key(REG_KEY1, k1);
    program_key(REG_KEY2, k2);
    program_key(REG_KEY3, k3);
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    block_t      plain, other;
    op_e         op;
    logic [31:0] a, b;
    logic        last;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0)
        calm_stretch = ($urandom_range(0, 3) == 0);
      op   = op_e'($urandom_range(0, 1));
      a    = pick_word();
      b    = pick_word();
      last = ($urandom_range(0, 7) == 0);
      // a share of round trips: feed the operation the output of its inverse
      if ($urandom_range(0, 3) == 0) begin
        plain = '{w0: a, w1: b, last: last};
        other = sb.cipher(op == OP_ENC ? OP_DEC : OP_ENC, plain);
        a = other.w0;
        b = other.w1;
      end
      send_block(op, a, b, last);
    end
  endtask

  initial begin
    logic [31:0] ct0, ct1;
    block_t      tmp;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Keys must read zero out of reset
    for (int i = 0; i < 4; i++) begin
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_e'(i), 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== 32'h0)
        sb.report($sformatf("key word %0d reads %h after reset", i, got));
    end

    // Directed: zero key
    calm_stretch = 1'b1;
    send_block(OP_ENC, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_block(OP_DEC, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_block(OP_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_block(OP_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    // Directed: byte-pattern key, then extremes and round trips
    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
    tmp = sb.cipher(OP_ENC, '{w0: 32'h4142_4344, w1: 32'h4546_4748, last: 1'b0});
    ct0 = tmp.w0;
    ct1 = tmp.w1;
    send_block(OP_ENC, 32'h4142_4344, 32'h4546_4748, 1'b0);
    send_block(OP_DEC, ct0, ct1, 1'b1);
    send_block(OP_ENC, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_block(OP_DEC, 32'h0000_0001, 32'h8000_0000, 1'b1);
    send_block(OP_ENC, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_block(OP_DEC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_block(OP_ENC, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_block(OP_DEC, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    // key change mid-stream: blocks after the load see the new key
    load_key(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(OP_ENC, 32'h4142_4344, 32'h4546_4748, 1'b0);
    send_block(OP_DEC, ct0, ct1, 1'b0);
    send_block(OP_ENC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_block(OP_DEC, 32'h0000_0000, 32'h0000_0000, 1'b1);
    calm_stretch = 1'b0;

    // Random phases over several keys, extremes first
    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(400);
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    run_random(200);
    drain();   // sender holds off until the pipeline is empty
    run_random(200);
    load_key(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h8000_0001);
    run_random(400);
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    no_gaps = 1'b1;
    run_random(400);

    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
